>>> rtl/core/hmq_pkg.sv
// ----------------------------------------------------------------------------
// hmq_pkg
// Shared types and constants of the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package hmq_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 11;
  localparam int EXT_W    = 64;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] min_value;
    logic [STATUS_W-1:0]       status;
    logic [OCC_W-1:0]          occupancy;
  } hmq_res_t;

endpackage

>>> rtl/core/hmq_ifs.sv
// ----------------------------------------------------------------------------
// hmq channel interfaces
// Valid/ready channels for the command request and the result.
// ----------------------------------------------------------------------------
interface hmq_in_if;
  import hmq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface hmq_out_if;
  import hmq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] min_value;
  logic [STATUS_W-1:0]       status;
  logic [OCC_W-1:0]          occupancy;

  modport source (output valid, output min_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input min_value, input status, input occupancy,
                  output ready);
endinterface

>>> rtl/core/hmq_cmp.sv
// ----------------------------------------------------------------------------
// hmq_cmp
// Shared signed less-than unit used by both sift directions.
// ----------------------------------------------------------------------------
module hmq_cmp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic                  lt
);

  assign lt = $signed(a) < $signed(b);

endmodule

>>> rtl/core/hmq_seq.sv
// ----------------------------------------------------------------------------
// hmq_seq
// Heap storage and the sequencer that runs sift-up and sift-down, one
// memory read and one compare per step.
// ----------------------------------------------------------------------------
module hmq_seq #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_command,
  input  logic signed [hmq_pkg::VALUE_W-1:0] in_value,
  output logic                              res_valid,
  input  logic                              res_ready,
  output hmq_pkg::hmq_res_t                 res
);
  import hmq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + 1;
  localparam int DW = DATA_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_RM_ROOT,
    S_RM_LAST,
    S_DN_RD,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [DW-1:0]       cur_r, cur_nxt;
  logic [DW-1:0]       pickv_r, pickv_nxt;
  logic                pickl_r, pickl_nxt;
  logic                rvalid_r, rvalid_nxt;
  logic [DW-1:0]       min_r, min_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic [DW-1:0]       mem [CAPACITY];
  logic [DW-1:0]       rdata_r;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [DW-1:0]       wdata;
  logic [AW-1:0]       raddr;

  logic [DW-1:0]       cmp_a, cmp_b;
  logic                lt;

  logic [AW-1:0]       pos_m1, parent;
  logic [XW-1:0]       left_x, right_x, count_x;
  logic [EXT_W-1:0]    min_ext;

  assign pos_m1  = pos_r - AW'(1);
  assign parent  = pos_m1 >> 1;
  assign left_x  = XW'({pos_r, 1'b1});
  assign right_x = left_x + XW'(1);
  assign count_x = XW'(count_r);

  hmq_cmp #(.DATA_WIDTH(DW)) u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (lt)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    cur_nxt    = cur_r;
    pickv_nxt  = pickv_r;
    pickl_nxt  = pickl_r;
    rvalid_nxt = rvalid_r;
    min_nxt    = min_r;
    status_nxt = status_r;
    we         = 1'b0;
    waddr      = pos_r;
    wdata      = cur_r;
    raddr      = '0;
    cmp_a      = cur_r;
    cmp_b      = rdata_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          min_nxt    = '0;
          status_nxt = ST_OK;
          if (in_command == CMD_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_FIN;
            end else begin
              cur_nxt   = DW'({{(EXT_W - VALUE_W){1'b0}}, in_value});
              pos_nxt   = AW'(count_r);
              count_nxt = count_r + CW'(1);
              state_nxt = S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_FIN;
            end else begin
              count_nxt = count_r - CW'(1);
              state_nxt = S_RM_ROOT;
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = S_FIN;
        end else begin
          raddr     = parent;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (lt) begin
          wdata     = rdata_r;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RM_ROOT: begin
        min_nxt   = rdata_r;
        raddr     = AW'(count_r);
        state_nxt = S_RM_LAST;
      end
      S_RM_LAST: begin
        cur_nxt   = rdata_r;
        pos_nxt   = '0;
        state_nxt = (count_r == '0) ? S_FIN : S_DN_RD;
      end
      S_DN_RD: begin
        if (left_x < count_x) begin
          raddr     = AW'(left_x);
          state_nxt = S_DN_LEFT;
        end else begin
          we        = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_DN_LEFT: begin
        cmp_a      = rdata_r;
        cmp_b      = cur_r;
        pickl_nxt  = lt;
        pickv_nxt  = lt ? rdata_r : cur_r;
        rvalid_nxt = right_x < count_x;
        if (right_x < count_x) begin
          raddr = AW'(right_x);
        end
        state_nxt = S_DN_RIGHT;
      end
      S_DN_RIGHT: begin
        cmp_a = rdata_r;
        cmp_b = pickv_r;
        we    = 1'b1;
        if (rvalid_r && lt) begin
          wdata     = rdata_r;
          pos_nxt   = AW'(right_x);
          state_nxt = S_DN_RD;
        end else if (pickl_r) begin
          wdata     = pickv_r;
          pos_nxt   = AW'(left_x);
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    pos_r    <= pos_nxt;
    cur_r    <= cur_nxt;
    pickv_r  <= pickv_nxt;
    pickl_r  <= pickl_nxt;
    rvalid_r <= rvalid_nxt;
    min_r    <= min_nxt;
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign min_ext       = EXT_W'(min_r);
  assign in_ready      = (state_r == S_IDLE);
  assign res_valid     = (state_r == S_FIN);
  assign res.min_value = VALUE_W'(min_ext);
  assign res.status    = status_r;
  assign res.occupancy = OCC_W'(count_r);

endmodule

>>> rtl/core/binary_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top
// Binary min-heap priority queue with insert and remove-min requests.
// ----------------------------------------------------------------------------
// One request is worked on at a time. The heap lives in a memory with one
// write and one registered read per cycle, and every step of a sift waits on
// that read. An insert climbs level by level from the new last slot, reading
// the parent and comparing at each level. A remove reads the root and then
// the last entry and, unless the heap is now empty, descends level by level,
// reading the left and then the right child at each. A rejected request
// (remove on empty, insert on full) goes straight to the result. The result
// then sits in an output register, so the next request is taken while it
// waits. No clearing pass after reset.
module binary_min_heap_queue_top #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  hmq_in_if.sink   in_ch,
  hmq_out_if.source out_ch
);
  import hmq_pkg::*;

  logic     res_valid;
  logic     res_ready;
  hmq_res_t res;
  logic     out_valid_r;
  hmq_res_t out_r;

  hmq_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_command (in_ch.command),
    .in_value   (in_ch.value),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.min_value = out_r.min_value;
  assign out_ch.status    = out_r.status;
  assign out_ch.occupancy = out_r.occupancy;

endmodule

>>> rtl/core/hmq_chk.sv
// ----------------------------------------------------------------------------
// hmq_chk
// Port-level checks of the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module hmq_chk #(
  parameter int CAPACITY = 1024
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [hmq_pkg::VALUE_W-1:0]       out_min_value,
  input logic [hmq_pkg::STATUS_W-1:0]      out_status,
  input logic [hmq_pkg::OCC_W-1:0]         out_occupancy
);
  import hmq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_min_value) &&
                                   $stable(out_status) && $stable(out_occupancy)))
    else $error("result dropped or changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_min_value == '0 && out_occupancy == '0))
    else $error("empty status with nonzero value or count");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |->
      (out_min_value == '0 && out_occupancy == OCC_W'(CAPACITY)))
    else $error("full status with wrong value or count");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous one in flight");

endmodule

bind binary_min_heap_queue_top hmq_chk #(.CAPACITY(CAPACITY)) u_hmq_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_min_value (out_ch.min_value),
  .out_status    (out_ch.status),
  .out_occupancy (out_ch.occupancy)
);
